### sv/hah_pkg.sv
package hah_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_INNER_RADIUS    = 2'd0;
	localparam logic [1:0] CFG_OUTER_RADIUS    = 2'd1;
	localparam logic [1:0] CFG_WANTED_PARTICLE = 2'd2;

	localparam logic [11:0] INNER_RADIUS_RESET    = 12'd850;
	localparam logic [11:0] OUTER_RADIUS_RESET    = 12'd1550;
	localparam logic [15:0] WANTED_PARTICLE_RESET = 16'd22;

	localparam logic [0:0] OP_HIT  = 1'b0;
	localparam logic [0:0] OP_READ = 1'b1;

	// Bin width is 20 units: divide by 4 with a shift, then by 5 with a reciprocal.
	// ceil(2^18 / 5) is exact for every quotient input below 2^18.
	localparam logic [15:0] RECIP_FIVE = 16'd52429;
	localparam int          RECIP_SHIFT = 18;

	localparam int NUM_HOLES = 4;

	typedef struct packed {
		logic signed [13:0] cx;
		logic signed [13:0] cy;
		logic        [25:0] r2;
	} hole_t;

	localparam hole_t HOLES [NUM_HOLES] = '{
		'{cx: -14'sd842, cy:  14'sd989,  r2: 26'd25600},
		'{cx: -14'sd989, cy: -14'sd533,  r2: 26'd25600},
		'{cx: -14'sd615, cy: -14'sd1300, r2: 26'd52900},
		'{cx:  14'sd370, cy: -14'sd650,  r2: 26'd40000}
	};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WORK
	} state_t;

	// Request to the bin store
	typedef struct packed {
		logic valid;
		logic incr;
		logic use_bin;
	} bin_req_t;

	// Classifier result: store request plus the bin coordinates to report
	typedef struct packed {
		bin_req_t   req;
		logic [7:0] col;
		logic [7:0] row;
	} cls_res_t;

endpackage

### sv/hah_hit_classifier.sv
module hah_hit_classifier #(
	parameter int BINS_PER_AXIS = 200,
	localparam int ADDR_W = $clog2(BINS_PER_AXIS * BINS_PER_AXIS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                operation,
	input  logic signed [15:0]  particle_code,
	input  logic                energy_missing,
	input  logic signed [12:0]  hit_x,
	input  logic signed [12:0]  hit_y,
	input  logic        [7:0]   read_col,
	input  logic        [7:0]   read_row,
	input  logic        [11:0]  inner_radius,
	input  logic        [11:0]  outer_radius,
	input  logic signed [15:0]  wanted_particle,
	output hah_pkg::cls_res_t   res,
	output logic [ADDR_W-1:0]   res_addr
);

	localparam int IDX_W = $clog2(BINS_PER_AXIS);
	localparam logic signed [16:0] HALF_SPAN = 17'(BINS_PER_AXIS * 10);
	localparam logic        [15:0] SPAN      = 16'(BINS_PER_AXIS * 20);

	// Stage 1: squares and offsets
	logic               v_s1;
	logic               op_s1;
	logic               pid_ok_s1;
	logic               rd_ok_s1;
	logic [7:0]         rcol_s1;
	logic [7:0]         rrow_s1;
	logic [24:0]        xx_s1;
	logic [24:0]        yy_s1;
	logic [23:0]        ri2_s1;
	logic [23:0]        ro2_s1;
	logic [24:0]        hdx2_s1 [hah_pkg::NUM_HOLES];
	logic [24:0]        hdy2_s1 [hah_pkg::NUM_HOLES];
	logic signed [16:0] sx_s1;
	logic signed [16:0] sy_s1;

	logic signed [25:0] xx_full;
	logic signed [25:0] yy_full;
	logic signed [13:0] hdx [hah_pkg::NUM_HOLES];
	logic signed [13:0] hdy [hah_pkg::NUM_HOLES];
	logic signed [27:0] hdx_sq [hah_pkg::NUM_HOLES];
	logic signed [27:0] hdy_sq [hah_pkg::NUM_HOLES];

	always_comb begin
		xx_full = hit_x * hit_x;
		yy_full = hit_y * hit_y;
		for (int i = 0; i < hah_pkg::NUM_HOLES; i++) begin
			hdx[i]    = {hit_x[12], hit_x} - hah_pkg::HOLES[i].cx;
			hdy[i]    = {hit_y[12], hit_y} - hah_pkg::HOLES[i].cy;
			hdx_sq[i] = hdx[i] * hdx[i];
			hdy_sq[i] = hdy[i] * hdy[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			op_s1     <= operation;
			pid_ok_s1 <= (particle_code == wanted_particle) && !energy_missing;
			rd_ok_s1  <= (read_col < BINS_PER_AXIS) && (read_row < BINS_PER_AXIS);
			rcol_s1   <= read_col;
			rrow_s1   <= read_row;
			xx_s1     <= xx_full[24:0];
			yy_s1     <= yy_full[24:0];
			ri2_s1    <= 24'(inner_radius) * 24'(inner_radius);
			ro2_s1    <= 24'(outer_radius) * 24'(outer_radius);
			for (int i = 0; i < hah_pkg::NUM_HOLES; i++) begin
				hdx2_s1[i] <= hdx_sq[i][24:0];
				hdy2_s1[i] <= hdy_sq[i][24:0];
			end
			sx_s1 <= {{4{hit_x[12]}}, hit_x} + HALF_SPAN;
			sy_s1 <= {{4{hit_y[12]}}, hit_y} + HALF_SPAN;
		end
	end

	// Stage 2: distance compares and bin quotients
	logic        v_s2;
	logic        op_s2;
	logic        rd_ok_s2;
	logic [7:0]  rcol_s2;
	logic [7:0]  rrow_s2;
	logic        hit_ok_s2;
	logic [10:0] qx_s2;
	logic [10:0] qy_s2;

	logic [25:0] r2;
	logic        rad_ok;
	logic        holes_ok;
	logic [25:0] hole_d2;
	logic        x_in;
	logic        y_in;
	logic [28:0] px;
	logic [28:0] py;

	always_comb begin
		r2       = {1'b0, xx_s1} + {1'b0, yy_s1};
		rad_ok   = (r2 >= {2'b0, ri2_s1}) && (r2 <= {2'b0, ro2_s1});
		holes_ok = 1'b1;
		hole_d2  = '0;
		for (int i = 0; i < hah_pkg::NUM_HOLES; i++) begin
			hole_d2 = {1'b0, hdx2_s1[i]} + {1'b0, hdy2_s1[i]};
			if (hole_d2 < hah_pkg::HOLES[i].r2) begin
				holes_ok = 1'b0;
			end
		end
		x_in = !sx_s1[16] && (sx_s1[15:0] < SPAN);
		y_in = !sy_s1[16] && (sy_s1[15:0] < SPAN);
		px   = 29'(sx_s1[14:2]) * 29'(hah_pkg::RECIP_FIVE);
		py   = 29'(sy_s1[14:2]) * 29'(hah_pkg::RECIP_FIVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			op_s2     <= op_s1;
			rd_ok_s2  <= rd_ok_s1;
			rcol_s2   <= rcol_s1;
			rrow_s2   <= rrow_s1;
			hit_ok_s2 <= pid_ok_s1 && rad_ok && holes_ok && x_in && y_in;
			qx_s2     <= px[28:hah_pkg::RECIP_SHIFT];
			qy_s2     <= py[28:hah_pkg::RECIP_SHIFT];
		end
	end

	// Stage 3: bin index and flat address
	logic                  v_s3;
	hah_pkg::cls_res_t     pay_s3;
	logic [ADDR_W-1:0]     addr_s3;

	logic [IDX_W+7:0]      rcol_ext;
	logic [IDX_W+7:0]      rrow_ext;
	logic [IDX_W-1:0]      col_idx;
	logic [IDX_W-1:0]      row_idx;
	logic [IDX_W+7:0]      col_ext;
	logic [IDX_W+7:0]      row_ext;
	logic                  is_read;
	hah_pkg::cls_res_t     pay_next;

	always_comb begin
		rcol_ext = {{IDX_W{1'b0}}, rcol_s2};
		rrow_ext = {{IDX_W{1'b0}}, rrow_s2};
		is_read  = (op_s2 == hah_pkg::OP_READ);
		if (is_read) begin
			col_idx = rcol_ext[IDX_W-1:0];
			row_idx = rrow_ext[IDX_W-1:0];
		end else begin
			col_idx = qx_s2[IDX_W-1:0];
			row_idx = qy_s2[IDX_W-1:0];
		end
		col_ext = {8'b0, col_idx};
		row_ext = {8'b0, row_idx};

		pay_next.req.valid = 1'b1;
		pay_next.req.incr  = !is_read && hit_ok_s2;
		if (is_read) begin
			pay_next.req.use_bin = rd_ok_s2;
			pay_next.col         = rcol_s2;
			pay_next.row         = rrow_s2;
		end else begin
			pay_next.req.use_bin = hit_ok_s2;
			pay_next.col         = hit_ok_s2 ? col_ext[7:0] : 8'd0;
			pay_next.row         = hit_ok_s2 ? row_ext[7:0] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			pay_s3  <= pay_next;
			addr_s3 <= ADDR_W'(row_idx) * ADDR_W'(BINS_PER_AXIS) + ADDR_W'(col_idx);
		end
	end

	always_comb begin
		res           = pay_s3;
		res.req.valid = v_s3;
	end

	assign res_addr = addr_s3;

endmodule

### sv/hah_bin_memory.sv
module hah_bin_memory #(
	parameter int DEPTH      = 40000,
	parameter int COUNT_BITS = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hah_pkg::bin_req_t      req,
	input  logic [ADDR_W-1:0]      req_addr,
	output logic                   clearing,
	output logic                   rsp_valid,
	output logic [COUNT_BITS-1:0]  rsp_count
);

	logic [COUNT_BITS-1:0] mem [DEPTH];

	logic                  clearing_q;
	logic [ADDR_W-1:0]     clr_q;

	logic                  v_s1;
	logic                  incr_s1;
	logic                  use_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [COUNT_BITS-1:0] rd_s1;

	logic                  we;
	logic [ADDR_W-1:0]     wa;
	logic [COUNT_BITS-1:0] wd;
	logic [COUNT_BITS-1:0] bumped;

	// Sweep zeros through the store after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			incr_s1 <= req.incr;
			use_s1  <= req.use_bin;
			addr_s1 <= req_addr;
			rd_s1   <= mem[req_addr];
		end
	end

	// Saturating increment; only one item is in flight, so no forwarding is needed
	always_comb begin
		bumped = (&rd_s1) ? rd_s1 : rd_s1 + 1'b1;
		if (clearing_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = v_s1 && incr_s1;
			wa = addr_s1;
			wd = bumped;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	assign clearing  = clearing_q;
	assign rsp_valid = v_s1;
	assign rsp_count = !use_s1 ? '0 : (incr_s1 ? bumped : rd_s1);

endmodule

### sv/hit_acceptance_histogrammer_unit.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------------
// item in  | start & !busy              | operation, particle_code, energy_missing,
//          |                            | hit_x, hit_y, read_col, read_row
// config   | cfg_valid & cfg_ready      | cfg_index, cfg_data
// result   | done (one-cycle strobe)    | accepted, bin_col, bin_row, bin_count
//
// Each item passes three classifier stages, one registered read of the bin store and
// one output register before the next beat can be accepted. The bin store does a
// read-modify-write without forwarding, so busy holds off a new beat until the
// result strobe. After reset the store is swept to zero over all
// BINS_PER_AXIS*BINS_PER_AXIS entries (40000 by default) with busy high;
// configuration writes are taken at any time.
// The receiver cannot stall: done is high for exactly one cycle per item.
module hit_acceptance_histogrammer_unit #(
	parameter int BINS_PER_AXIS = 200,
	parameter int COUNT_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic signed [15:0]  particle_code,
	input  logic                energy_missing,
	input  logic signed [12:0]  hit_x,
	input  logic signed [12:0]  hit_y,
	input  logic        [7:0]   read_col,
	input  logic        [7:0]   read_row,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic        [1:0]   cfg_index,
	input  logic        [15:0]  cfg_data,
	output logic                done,
	output logic                accepted,
	output logic        [7:0]   bin_col,
	output logic        [7:0]   bin_row,
	output logic        [31:0]  bin_count
);

	localparam int DEPTH  = BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [11:0]        inner_q;
	logic [11:0]        outer_q;
	logic signed [15:0] wanted_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q  <= hah_pkg::INNER_RADIUS_RESET;
			outer_q  <= hah_pkg::OUTER_RADIUS_RESET;
			wanted_q <= hah_pkg::WANTED_PARTICLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hah_pkg::CFG_INNER_RADIUS:    inner_q  <= cfg_data[11:0];
				hah_pkg::CFG_OUTER_RADIUS:    outer_q  <= cfg_data[11:0];
				hah_pkg::CFG_WANTED_PARTICLE: wanted_q <= cfg_data;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	hah_pkg::state_t state_q;
	hah_pkg::state_t state_d;
	logic            in_beat;
	logic            clearing;
	logic            rsp_valid;
	logic [COUNT_BITS-1:0] rsp_count;

	hah_pkg::cls_res_t  cls_res;
	logic [ADDR_W-1:0]  cls_addr;

	assign in_beat = start && !busy;

	hah_hit_classifier #(
		.BINS_PER_AXIS (BINS_PER_AXIS)
	) u_classifier (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_beat),
		.operation       (operation),
		.particle_code   (particle_code),
		.energy_missing  (energy_missing),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.read_col        (read_col),
		.read_row        (read_row),
		.inner_radius    (inner_q),
		.outer_radius    (outer_q),
		.wanted_particle (wanted_q),
		.res             (cls_res),
		.res_addr        (cls_addr)
	);

	hah_bin_memory #(
		.DEPTH      (DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_bin_memory (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (cls_res.req),
		.req_addr  (cls_addr),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_count (rsp_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hah_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			hah_pkg::ST_CLEAR: begin
				if (!clearing) begin
					state_d = hah_pkg::ST_IDLE;
				end
			end
			hah_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = hah_pkg::ST_WORK;
				end
			end
			hah_pkg::ST_WORK: begin
				if (rsp_valid) begin
					state_d = hah_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hah_pkg::ST_CLEAR;
			end
		endcase
	end

	// Hold the reported coordinates until the store answers
	logic       incr_q;
	logic [7:0] col_q;
	logic [7:0] row_q;

	always_ff @(posedge clk) begin
		if (cls_res.req.valid) begin
			incr_q <= cls_res.req.incr;
			col_q  <= cls_res.col;
			row_q  <= cls_res.row;
		end
	end

	logic                   done_q;
	logic                   accepted_q;
	logic [7:0]             bin_col_q;
	logic [7:0]             bin_row_q;
	logic [31:0]            bin_count_q;
	logic [COUNT_BITS+31:0] count_ext;

	assign count_ext = {32'b0, rsp_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid) begin
			accepted_q  <= incr_q;
			bin_col_q   <= col_q;
			bin_row_q   <= row_q;
			bin_count_q <= count_ext[31:0];
		end
	end

	assign done      = done_q;
	assign accepted  = accepted_q;
	assign bin_col   = bin_col_q;
	assign bin_row   = bin_row_q;
	assign bin_count = bin_count_q;

`ifndef SYNTHESIS
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> busy)
		else $error("accepted beat did not raise busy");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_req_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		cls_res.req.valid |-> (state_q == hah_pkg::ST_WORK))
		else $error("store request outside of item work");

	a_clear_ends_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> (state_q == hah_pkg::ST_CLEAR))
		else $error("clearing pass ended outside clear state");
`endif

endmodule
